/* design/lsm_pkg.sv */
// Shared types and constants for the load share monitor.
// No dependencies.
package lsm_pkg;

  localparam int unsigned PctW = 7;
  localparam int unsigned FpsW = 16;
  localparam int unsigned TotalW = 39;
  localparam int unsigned PctOuts = 6;

  localparam logic [1:0] KIND_POLL = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_PROCESS = 2'd2;

  localparam logic [31:0] TICK_RESET = 32'd10;
  localparam logic [15:0] FRAME_RESET = 16'd5;
  localparam logic [PctW-1:0] PCT_RESET = 7'd10;
  localparam logic [FpsW-1:0] FPS_RESET = 16'd10;
  localparam logic [31:0] STAMP_RESET = 32'd500;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_FRAME,
    ST_FPS,
    ST_TGT,
    ST_DIV,
    ST_PCT,
    ST_OUT
  } state_t;

  // Step toward target by diff/5+1, where the division goes through a
  // reciprocal multiply; values are narrow (at most 16 bits).
  function automatic logic [16:0] div5(input logic [16:0] d);
    logic [35:0] p;
    p = 36'(d) * 36'd52429;
    return 17'(p >> 18);
  endfunction

endpackage

/* design/load_share_monitor.sv */
// Top level of the load share monitor: tick and frame memories, the window
// walk, a shift-subtract divider for the shares and the output register.
// Depends on lsm_pkg.
//
// channel | direction | handshake     | payload
// in      | input     | in_valid/stall| kind, tick_type, now_ms, frame_rate
// out     | output    | out_valid/st  | smoothed_fps, pct_type0..5, window_total
//
// A poll item writes the tick memory (when its type is in range) and a frame
// item the frame memory. A process item reads the tick memory once per entry,
// then the frame memory, then runs a 46-step divider per type; out_valid
// rises after the last type. No item is taken while a result waits. Every
// memory is cleared by a pass after reset, during which in_stall is high.
module load_share_monitor import lsm_pkg::*; #(
  parameter int unsigned TICK_TYPES = 6,
  parameter int unsigned WINDOW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [2:0]        tick_type,
  input  logic [31:0]       now_ms,
  input  logic [15:0]       frame_rate,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [FpsW-1:0]   smoothed_fps,
  output logic [PctW-1:0]   pct_type0,
  output logic [PctW-1:0]   pct_type1,
  output logic [PctW-1:0]   pct_type2,
  output logic [PctW-1:0]   pct_type3,
  output logic [PctW-1:0]   pct_type4,
  output logic [PctW-1:0]   pct_type5,
  output logic [TotalW-1:0] window_total
);

  localparam int unsigned SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned TypeW = (TICK_TYPES > 1) ? $clog2(TICK_TYPES) : 1;
  localparam int unsigned Depth = TICK_TYPES * WINDOW;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned FsumW = 16 + SlotW + 1;
  localparam int unsigned DivW = 6;
  // The frame average is a multiply by a rounded-up reciprocal of WINDOW,
  // exact for every sum that fits in FsumW bits.
  localparam int unsigned FShift = FsumW + SlotW;
  localparam longint unsigned FRecip =
    ((64'd1 << FShift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam int unsigned FRecipW = FsumW + 2;
  localparam int unsigned FprodW = FsumW + FRecipW;

  logic [31:0] tick_mem [Depth];
  logic [15:0] frame_mem [WINDOW];
  logic [31:0] tick_rd;
  logic [15:0] frame_rd;

  logic [PctW-1:0] share [TICK_TYPES];
  logic [TotalW-1:0] sums [TICK_TYPES];

  state_t state, state_next;
  logic clearing;
  logic [CntW-1:0] cnt;
  logic [SlotW-1:0] slot_index;
  logic [31:0] last_stamp;
  logic [FpsW-1:0] fps_smooth;
  logic [TypeW-1:0] ty;
  logic [TypeW-1:0] ty_d;
  logic [SlotW-1:0] sl;
  logic rd_pend;
  logic [FsumW-1:0] fsum;
  logic [TotalW-1:0] total;
  logic [TotalW+6:0] num;
  logic [TotalW-1:0] rem;
  logic [DivW:0] quo;
  logic [DivW-1:0] bitc;

  logic in_acc;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic wr_en;
  logic [31:0] wr_data;
  logic [SlotW-1:0] slot_inc;

  assign in_stall = clearing || (state != ST_IDLE) || out_valid;
  assign in_acc = in_valid && !in_stall;
  assign slot_inc = (32'(slot_index) == WINDOW - 1) ? '0 : slot_index + 1'b1;

  // Clear pass or a poll write.
  always_comb begin
    if (clearing) begin
      wr_en = 1'b1;
      wr_addr = AddrW'(cnt);
      wr_data = TICK_RESET;
    end else begin
      wr_en = in_acc && (kind == KIND_POLL) && (32'(tick_type) < TICK_TYPES);
      wr_addr = AddrW'(32'(tick_type) * WINDOW + 32'(slot_index));
      wr_data = now_ms - last_stamp;
    end
  end

  assign rd_addr = AddrW'(32'(ty) * WINDOW + 32'(sl));

  always_ff @(posedge clk) begin
    if (wr_en) tick_mem[wr_addr] <= wr_data;
    tick_rd <= tick_mem[rd_addr];
    if (clearing && 32'(cnt) < WINDOW) frame_mem[SlotW'(cnt)] <= FRAME_RESET;
    else if (in_acc && kind == KIND_FRAME) frame_mem[slot_index] <= frame_rate;
    frame_rd <= frame_mem[sl];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc && kind == KIND_PROCESS) state_next = ST_SUM;
      ST_SUM: if (rd_pend && 32'(ty) == 0 && sl == '0 && cnt != '0) state_next = ST_FRAME;
      ST_FRAME: if (rd_pend && sl == '0) state_next = ST_FPS;
      ST_FPS: state_next = ST_TGT;
      ST_TGT: state_next = ST_DIV;
      ST_DIV: if (bitc == '0) state_next = ST_PCT;
      ST_PCT: state_next = (32'(ty) == TICK_TYPES - 1) ? ST_OUT : ST_TGT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  logic [16:0] fd;
  logic [FpsW-1:0] favg;
  logic [FprodW-1:0] fprod;
  logic [PctW-1:0] pv, pt;
  logic [16:0] pd;
  logic [TotalW:0] trial;

  always_comb begin
    fprod = FprodW'(fsum) * FprodW'(FRecip);
    favg = 16'(fprod >> FShift);
    fd = (fps_smooth > favg) ? 17'(fps_smooth - favg) : 17'(favg - fps_smooth);
    pv = share[ty];
    pt = PctW'(quo);
    pd = (pv > pt) ? 17'(pv - pt) : 17'(pt - pv);
    trial = {rem, num[TotalW+6]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      clearing <= 1'b1;
      cnt <= '0;
      slot_index <= '0;
      last_stamp <= STAMP_RESET;
      fps_smooth <= FPS_RESET;
      out_valid <= 1'b0;
      ty <= '0;
      sl <= '0;
      rd_pend <= 1'b0;
      for (int i = 0; i < TICK_TYPES; i++) share[i] <= PCT_RESET;
    end else begin
      state <= state_next;
      if (clearing) begin
        if (32'(cnt) == Depth - 1) begin
          clearing <= 1'b0;
          cnt <= '0;
        end else cnt <= cnt + 1'b1;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (in_acc && kind == KIND_POLL) last_stamp <= now_ms;
      unique case (state)
        ST_IDLE: if (in_acc && kind == KIND_PROCESS) begin
          slot_index <= slot_inc;
          ty <= '0;
          sl <= '0;
          rd_pend <= 1'b0;
          cnt <= '0;
          total <= TotalW'(1);
          for (int i = 0; i < TICK_TYPES; i++) sums[i] <= '0;
        end
        ST_SUM: begin
          // Address walks one entry ahead of the accumulating data.
          if (rd_pend) begin
            sums[ty_d] <= sums[ty_d] + TotalW'(tick_rd);
            total <= total + TotalW'(tick_rd);
          end
          if (32'(cnt) < Depth) begin
            cnt <= cnt + 1'b1;
            rd_pend <= 1'b1;
            ty_d <= ty;
            if (32'(sl) == WINDOW - 1) begin
              sl <= '0;
              ty <= (32'(ty) == TICK_TYPES - 1) ? '0 : ty + 1'b1;
            end else sl <= sl + 1'b1;
          end
          if (state_next == ST_FRAME) begin
            sl <= (WINDOW > 1) ? SlotW'(1) : '0;
            fsum <= '0;
            rd_pend <= 1'b1;
            ty <= '0;
          end
        end
        ST_FRAME: begin
          fsum <= fsum + FsumW'(frame_rd);
          sl <= (32'(sl) == WINDOW - 1) ? '0 : sl + 1'b1;
        end
        ST_FPS: begin
          if (fps_smooth > favg) fps_smooth <= fps_smooth - 16'(div5(fd) + 1'b1);
          else if (fps_smooth < favg) fps_smooth <= fps_smooth + 16'(div5(fd) + 1'b1);
        end
        ST_TGT: begin
          // Times one hundred as 64 + 32 + 4.
          num <= ((TotalW+7)'(sums[ty]) << 6) + ((TotalW+7)'(sums[ty]) << 5)
                 + ((TotalW+7)'(sums[ty]) << 2);
          rem <= '0;
          quo <= '0;
          bitc <= DivW'(TotalW + 7);
        end
        ST_DIV: begin
          if (bitc != '0) begin
            bitc <= bitc - 1'b1;
            num <= num << 1;
            if (trial >= (TotalW+1)'(total)) begin
              rem <= TotalW'(trial - (TotalW+1)'(total));
              quo <= {quo[DivW-1:0], 1'b1};
            end else begin
              rem <= TotalW'(trial);
              quo <= {quo[DivW-1:0], 1'b0};
            end
          end
        end
        ST_PCT: begin
          if (pv > pt) share[ty] <= pv - PctW'(div5(pd) + 1'b1);
          else if (pv < pt) share[ty] <= pv + PctW'(div5(pd) + 1'b1);
          ty <= (32'(ty) == TICK_TYPES - 1) ? '0 : ty + 1'b1;
        end
        ST_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    smoothed_fps = fps_smooth;
    window_total = total;
    pct_type0 = (TICK_TYPES > 0) ? share[0] : '0;
    pct_type1 = (TICK_TYPES > 1) ? share[TypeW'(1 % TICK_TYPES)] : '0;
    pct_type2 = (TICK_TYPES > 2) ? share[TypeW'(2 % TICK_TYPES)] : '0;
    pct_type3 = (TICK_TYPES > 3) ? share[TypeW'(3 % TICK_TYPES)] : '0;
    pct_type4 = (TICK_TYPES > 4) ? share[TypeW'(4 % TICK_TYPES)] : '0;
    pct_type5 = (TICK_TYPES > 5) ? share[TypeW'(5 % TICK_TYPES)] : '0;
  end

endmodule

/* tb/tb_load_share_monitor.sv */
// Testbench for load_share_monitor: drives poll, frame, spare and process
// items and checks every window summary against a behavioural predictor of
// the block. Depends on lsm_pkg and the load_share_monitor RTL.
`timescale 1ns / 100ps

module tb_load_share_monitor;
  import lsm_pkg::*;

  localparam int NTYPES = 6;
  localparam int NSLOTS = 16;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1880;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [FpsW-1:0]   fps;
    logic [PctW-1:0]   p0, p1, p2, p3, p4, p5;
    logic [TotalW-1:0] total;
  } summary_t;

  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  ttype;
    logic [31:0] stamp;
    logic [15:0] rate;
    bit          typed;
    summary_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = '0;
  logic [2:0] tick_type = '0;
  logic [31:0] now_ms = '0;
  logic [15:0] frame_rate = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FpsW-1:0] smoothed_fps;
  logic [PctW-1:0] pct_type0, pct_type1, pct_type2, pct_type3, pct_type4, pct_type5;
  logic [TotalW-1:0] window_total;

  load_share_monitor dut (.*);

  always #6 clk = ~clk;

  // Predictor state.
  logic [31:0] mon_ticks [NTYPES][NSLOTS];
  logic [15:0] mon_rates [NSLOTS];
  logic [PctW-1:0] mon_share [NTYPES];
  logic [FpsW-1:0] mon_fps;
  int mon_slot;
  logic [31:0] mon_stamp;

  summary_t pending_summaries[$];
  summary_t typed_summaries[$];
  bit typed_flags[$];
  int mismatches = 0;
  int summaries_seen = 0;
  longint cycles = 0;
  bit quiet_phase = 1'b0;
  bit hold_off = 1'b0;

  function automatic longint step_toward(longint v, longint target);
    if (v > target) v -= (v - target) / 5 + 1;
    else if (v < target) v += (target - v) / 5 + 1;
    return v;
  endfunction

  task automatic monitor_reset();
    for (int t = 0; t < NTYPES; t++) begin
      for (int j = 0; j < NSLOTS; j++) mon_ticks[t][j] = TICK_RESET;
      mon_share[t] = PCT_RESET;
    end
    for (int j = 0; j < NSLOTS; j++) mon_rates[j] = FRAME_RESET;
    mon_fps = FPS_RESET;
    mon_slot = 0;
    mon_stamp = STAMP_RESET;
  endtask

  // Applies one item; returns 1 with the summary when a process item.
  function automatic bit summarise(input logic [1:0] k, input logic [2:0] tt,
                                   input logic [31:0] stamp, input logic [15:0] rate,
                                   output summary_t s);
    longint unsigned sums[NTYPES];
    longint unsigned total, frames;
    longint v;
    s = '0;
    total = 0;
    frames = 0;
    if (k == KIND_POLL) begin
      if (tt < NTYPES) mon_ticks[tt][mon_slot] = stamp - mon_stamp;
      mon_stamp = stamp;
      return 1'b0;
    end
    if (k == KIND_FRAME) begin
      mon_rates[mon_slot] = rate;
      return 1'b0;
    end
    if (k != KIND_PROCESS) return 1'b0;
    mon_slot = (mon_slot + 1) % NSLOTS;
    for (int t = 0; t < NTYPES; t++) begin
      sums[t] = 0;
      for (int j = 0; j < NSLOTS; j++) sums[t] += mon_ticks[t][j];
      total += sums[t];
    end
    total += 1;
    for (int j = 0; j < NSLOTS; j++) frames += mon_rates[j];
    frames /= NSLOTS;
    v = step_toward(longint'(mon_fps), longint'(frames));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    mon_fps = v[15:0];
    for (int t = 0; t < NTYPES; t++) begin
      v = step_toward(longint'(mon_share[t]), longint'(sums[t] * 100 / total));
      if (v < 0) v = 0;
      if (v > 100) v = 100;
      mon_share[t] = v[6:0];
    end
    s.fps = mon_fps;
    s.p0 = mon_share[0]; s.p1 = mon_share[1]; s.p2 = mon_share[2];
    s.p3 = mon_share[3]; s.p4 = mon_share[4]; s.p5 = mon_share[5];
    s.total = total[TotalW-1:0];
    return 1'b1;
  endfunction

  // Sends one item, waiting for acceptance; idles at random beforehand.
  task automatic send_item(input row_t r);
    summary_t s;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= r.kind;
    tick_type <= r.ttype;
    now_ms <= r.stamp;
    frame_rate <= r.rate;
    do @(posedge clk); while (in_stall);
    if (summarise(r.kind, r.ttype, r.stamp, r.rate, s)) begin
      pending_summaries.push_back(s);
      typed_flags.push_back(r.typed);
      typed_summaries.push_back(r.want);
    end
  endtask

  function automatic row_t mk(logic [1:0] k, logic [2:0] tt, logic [31:0] stamp,
                              logic [15:0] rate);
    row_t r;
    r.kind = k; r.ttype = tt; r.stamp = stamp; r.rate = rate;
    r.typed = 1'b0; r.want = '0;
    return r;
  endfunction

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // Checker of summaries.
  always @(posedge clk) begin
    summary_t e, t;
    bit typed;
    if (!rst && out_valid && !out_stall) begin
      summaries_seen++;
      if (pending_summaries.size() == 0) begin
        report("unexpected summary", 0, 1);
      end else begin
        e = pending_summaries.pop_front();
        t = typed_summaries.pop_front();
        typed = typed_flags.pop_front();
        // A typed-in row must also agree with the predictor.
        if (typed && t != e) report("typed-in row vs predictor", t.total, e.total);
        if (smoothed_fps !== e.fps) report("smoothed_fps", e.fps, smoothed_fps);
        if (pct_type0 !== e.p0) report("pct_type0", e.p0, pct_type0);
        if (pct_type1 !== e.p1) report("pct_type1", e.p1, pct_type1);
        if (pct_type2 !== e.p2) report("pct_type2", e.p2, pct_type2);
        if (pct_type3 !== e.p3) report("pct_type3", e.p3, pct_type3);
        if (pct_type4 !== e.p4) report("pct_type4", e.p4, pct_type4);
        if (pct_type5 !== e.p5) report("pct_type5", e.p5, pct_type5);
        if (window_total !== e.total) report("window_total", e.total, window_total);
      end
    end
  end

  // Receiver stalls: random bursts, one long hold-off, none at the end.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (2000) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    row_t dir[$];
    row_t r;
    logic [31:0] stamp;
    int pick;
    monitor_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: first process straight after reset gives known values.
    r = mk(KIND_PROCESS, 3'd0, 32'd0, 16'd0);
    r.typed = 1'b1;
    r.want = '{fps: 16'd8, p0: 7'd12, p1: 7'd12, p2: 7'd12, p3: 7'd12,
               p4: 7'd12, p5: 7'd12, total: 39'd961};
    dir.push_back(r);
    dir.push_back(mk(KIND_POLL, 3'd0, 32'hFFFF_FFFF, 16'hFFFF));
    dir.push_back(mk(KIND_POLL, 3'd1, 32'd0, 16'd0));          // stamp wraps
    dir.push_back(mk(KIND_POLL, 3'd7, 32'h8000_0000, 16'd0));  // type out of range
    dir.push_back(mk(KIND_POLL, 3'd6, 32'h0000_0001, 16'd0));
    dir.push_back(mk(KIND_FRAME, 3'd7, 32'hFFFF_FFFF, 16'hFFFF));
    dir.push_back(mk(KIND_SPARE, 3'd2, 32'd1234, 16'd77));     // ignored kind
    dir.push_back(mk(KIND_PROCESS, 3'd5, 32'hFFFF_FFFF, 16'hFFFF));
    for (int t = 0; t < NTYPES; t++)
      dir.push_back(mk(KIND_POLL, t[2:0], 32'hFFFF_FFFF - t, 16'd0));
    dir.push_back(mk(KIND_FRAME, 3'd0, 32'd0, 16'd0));
    for (int i = 0; i < 8; i++) dir.push_back(mk(KIND_PROCESS, 3'd0, 32'd0, 16'd0));
    foreach (dir[i]) send_item(dir[i]);

    // Random part: mostly poll bursts and frames with a process every so often.
    stamp = $urandom;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) hold_off = 1'b1;
      if (i == RANDOM_ITEMS - 200) quiet_phase = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        stamp += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5000);
        r = mk(KIND_POLL, ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                        : 3'($urandom_range(0, 5)),
               stamp, 16'($urandom));
      end else if (pick < 75) begin
        r = mk(KIND_FRAME, 3'($urandom), $urandom,
               ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120)));
      end else if (pick < 97) begin
        r = mk(KIND_PROCESS, 3'($urandom), $urandom, 16'($urandom));
      end else begin
        r = mk(KIND_SPARE, 3'($urandom), $urandom, 16'($urandom));
      end
      send_item(r);
    end
    in_valid <= 1'b0;

    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Ran %0d summaries over poll, frame, ignored and process items,",
             summaries_seen);
    $display("with wrapping stamps, out-of-range types and a long output hold-off.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
